// ===== hdl/peak_events_in_time_window_assert.svh =====
// Assertion macros used by the verification module of the peak event counter.
`ifndef PEAK_EVENTS_IN_TIME_WINDOW_ASSERT_SVH
`define PEAK_EVENTS_IN_TIME_WINDOW_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PEWIN_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define PEWIN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/pewin_pkg.sv =====
package pewin_pkg;

   localparam int DEPTH     = 1024;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int OCC_W     = $clog2(DEPTH + 1);
   localparam int STAMP_W   = 32;
   localparam int COUNT_W   = 11;
   localparam int RSP_DATA_W = 24;
   localparam logic [STAMP_W-1:0] WINDOW_RESET = STAMP_W'(60);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic                wr_en;
      logic [ADDR_W-1:0]   wr_addr;
      logic [STAMP_W-1:0]  wr_data;
      logic [ADDR_W-1:0]   rd_addr;
   } ring_cmd_type;

   typedef struct packed {
      logic [COUNT_W-1:0] in_window;
      logic [COUNT_W-1:0] peak_count;
      logic               overflowed;
      logic               run_done;
   } result_type;

   function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] slot);
      logic [ADDR_W-1:0] nxt;
      if (slot == ADDR_W'(DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = slot + ADDR_W'(1);
      end
      return nxt;
   endfunction

endpackage

// ===== hdl/peak_events_in_time_window.sv =====
// Sliding-window event counter with a running peak.
// The req_ channel carries one event timestamp in seconds per transaction in
// req_tdata, non-decreasing within a run; req_tlast marks the last stamp of a run.
// Each transaction yields exactly one rsp_ transaction: the number of stored stamps
// inside the window (including the new one), the peak of that count in this run,
// a sticky overflow flag, and rsp_tlast echoing the end-of-run mark.
// The window length is written through csr_tdata (csr_tready is always high) and
// must only be changed while no transaction is in flight.
// Stamps live in a 1024-entry ring memory with a registered read port. A result is
// offered once its item has been checked against the oldest stored stamps, each
// stamp that expires being dropped in turn; the next item is taken in the cycle in
// which that result is first offered, so no new stamp is accepted while the last
// one is still being processed.
// A full result register lets the next item be accepted while a result waits; if the
// receiver keeps rsp_tready low, the block finishes that item and then holds it until
// the register drains, keeping req_tready low.
// Reset empties the ring, clears the peak and overflow flag and sets the window to
// 60 seconds; no clearing pass is needed. End of run clears the same run state.
module peak_events_in_time_window (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [pewin_pkg::STAMP_W-1:0]       req_tdata,   // [31:0] stamp
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pewin_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [10:0] in_window,
                                                            // [21:11] peak_count,
                                                            // [22] overflowed, [23] zero
   output logic                                rsp_tlast,
   input  logic                                csr_tvalid,
   output logic                                csr_tready,
   input  logic [pewin_pkg::STAMP_W-1:0]       csr_tdata    // [31:0] window_seconds
);
   import pewin_pkg::*;

   ring_cmd_type       ring_cmd;
   logic [STAMP_W-1:0] ring_rd_data;
   logic               result_load;
   result_type         result;
   logic               out_free;

   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff, rsp_in;

   pewin_ring u_ring (
      .clock   (clock),
      .cmd     (ring_cmd),
      .rd_data (ring_rd_data)
   );

   pewin_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_stamp    (req_tdata),
      .req_last     (req_tlast),
      .csr_valid    (csr_tvalid),
      .csr_data     (csr_tdata),
      .out_free     (out_free),
      .result_load  (result_load),
      .result       (result),
      .ring_cmd     (ring_cmd),
      .ring_rd_data (ring_rd_data)
   );

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = result_load || (rsp_valid_ff && !rsp_tready);
   assign rsp_in       = result_load ? result : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign csr_tready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.overflowed, rsp_ff.peak_count, rsp_ff.in_window};
   assign rsp_tlast  = rsp_ff.run_done;

endmodule

// ===== hdl/pewin_ring.sv =====
module pewin_ring (
   input  logic                                clock,
   input  pewin_pkg::ring_cmd_type             cmd,
   output logic [pewin_pkg::STAMP_W-1:0]       rd_data
);
   import pewin_pkg::*;

   logic [STAMP_W-1:0] ring_mem [DEPTH];
   logic [STAMP_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         ring_mem[cmd.wr_addr] <= cmd.wr_data;
      end
      rd_data_ff <= ring_mem[cmd.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/pewin_ctrl.sv =====
module pewin_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [pewin_pkg::STAMP_W-1:0]       req_stamp,
   input  logic                                req_last,
   input  logic                                csr_valid,
   input  logic [pewin_pkg::STAMP_W-1:0]       csr_data,
   input  logic                                out_free,
   output logic                                result_load,
   output pewin_pkg::result_type               result,
   output pewin_pkg::ring_cmd_type             ring_cmd,
   input  logic [pewin_pkg::STAMP_W-1:0]       ring_rd_data
);
   import pewin_pkg::*;

   state_type          state_ff, state_in;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;
   logic               last_ff, last_in;
   logic [ADDR_W-1:0]  oldest_ff, oldest_in;
   logic [OCC_W-1:0]   occ_ff, occ_in;
   logic [OCC_W-1:0]   best_ff, best_in;
   logic               ovf_ff, ovf_in;
   logic [STAMP_W-1:0] window_ff, window_in;

   logic               expire;
   logic               full;
   logic               commit;
   logic [ADDR_W-1:0]  base_oldest;
   logic [OCC_W-1:0]   base_occ;
   logic [ADDR_W:0]    slot_sum;
   logic [ADDR_W-1:0]  wr_slot;
   logic [OCC_W-1:0]   occ_commit;
   logic [OCC_W-1:0]   best_commit;

   // A stored stamp leaves the window only when it is strictly older than the new one.
   assign expire = (stamp_ff > ring_rd_data) && ((stamp_ff - ring_rd_data) > window_ff);

   // Store the new stamp: a full ring gives up its oldest entry first.
   always_comb begin
      full        = (occ_ff == OCC_W'(DEPTH));
      base_oldest = full ? next_slot(oldest_ff) : oldest_ff;
      base_occ    = full ? OCC_W'(DEPTH - 1) : occ_ff;
      slot_sum    = {1'b0, base_oldest} + (ADDR_W + 1)'(base_occ);
      if (slot_sum >= (ADDR_W + 1)'(DEPTH)) begin
         wr_slot = ADDR_W'(slot_sum - (ADDR_W + 1)'(DEPTH));
      end else begin
         wr_slot = ADDR_W'(slot_sum);
      end
      occ_commit  = base_occ + OCC_W'(1);
      best_commit = (occ_commit > best_ff) ? occ_commit : best_ff;
   end

   assign window_in = csr_valid ? csr_data : window_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         oldest_ff <= '0;
         occ_ff    <= '0;
         best_ff   <= '0;
         ovf_ff    <= 1'b0;
         window_ff <= WINDOW_RESET;
      end else begin
         state_ff  <= state_in;
         oldest_ff <= oldest_in;
         occ_ff    <= occ_in;
         best_ff   <= best_in;
         ovf_ff    <= ovf_in;
         window_ff <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      stamp_ff <= stamp_in;
      last_ff  <= last_in;
   end

   always_comb begin
      state_in  = state_ff;
      stamp_in  = stamp_ff;
      last_in   = last_ff;
      oldest_in = oldest_ff;
      occ_in    = occ_ff;
      best_in   = best_ff;
      ovf_in    = ovf_ff;
      req_ready = 1'b0;
      commit    = 1'b0;
      ring_cmd.rd_addr = oldest_ff;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               stamp_in = req_stamp;
               last_in  = req_last;
               state_in = (occ_ff == '0) ? ST_WRITE : ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (expire) begin
               oldest_in        = next_slot(oldest_ff);
               occ_in           = occ_ff - OCC_W'(1);
               ring_cmd.rd_addr = next_slot(oldest_ff);
               state_in         = (occ_ff == OCC_W'(1)) ? ST_WRITE : ST_CHECK;
            end else if (out_free) begin
               commit = 1'b1;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               commit = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (commit) begin
         state_in = ST_IDLE;
         if (last_ff) begin
            oldest_in = '0;
            occ_in    = '0;
            best_in   = '0;
            ovf_in    = 1'b0;
         end else begin
            oldest_in = base_oldest;
            occ_in    = occ_commit;
            best_in   = best_commit;
            ovf_in    = ovf_ff | full;
         end
      end

      ring_cmd.wr_en   = commit;
      ring_cmd.wr_addr = wr_slot;
      ring_cmd.wr_data = stamp_ff;
   end

   assign result_load       = commit;
   assign result.in_window  = COUNT_W'(occ_commit);
   assign result.peak_count = COUNT_W'(best_commit);
   assign result.overflowed = ovf_ff | full;
   assign result.run_done   = last_ff;

endmodule

// ===== hdl/pewin_assert_chk.sv =====
`include "peak_events_in_time_window_assert.svh"

module pewin_assert_chk (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [pewin_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input logic                                rsp_tlast
);

   // A stalled result keeps its payload.
   `PEWIN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // The peak can never be below the current count, and a count includes the new stamp.
   `PEWIN_ASSERT_NOW(a_peak_ge_count, clock, reset, rsp_tvalid,
      (rsp_tdata[21:11] >= rsp_tdata[10:0]) && (rsp_tdata[10:0] != 11'd0))

   // The sequencer is busy in the cycle after it takes a stamp.
   `PEWIN_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready,
      !req_tready)

   // A result only appears after a stamp has been taken.
   `PEWIN_ASSERT_NEXT(a_no_result_from_idle, clock, reset,
      !rsp_tvalid && !(req_tvalid && req_tready) && req_tready, !rsp_tvalid)

endmodule

bind peak_events_in_time_window pewin_assert_chk u_pewin_assert_chk (.*);

// ===== sim/testbench.sv =====
module testbench;
   import pewin_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_ITEMS = 700;
   localparam int PHASES = 8;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam logic [STAMP_W-1:0] STAMP_MAX = 32'hFFFF_FFFF;

   // Predicts the window count, the run peak and the sticky overflow flag for
   // every accepted stamp, and checks the results in order against them.
   class window_count_board;
      logic [STAMP_W-1:0] window_len;
      logic [STAMP_W-1:0] ring [DEPTH];
      int unsigned head;
      int unsigned held;
      int unsigned peak;
      bit overflow;
      result_type expected_counts [$];
      int errors;

      function new();
         window_len = WINDOW_RESET;
         errors = 0;
         clear_run();
      endfunction

      function void clear_run();
         head = 0;
         held = 0;
         peak = 0;
         overflow = 1'b0;
      endfunction

      function int pending();
         return expected_counts.size();
      endfunction

      function void note_stamp(logic [STAMP_W-1:0] stamp, logic last);
         result_type want;
         // Stamps older than the window are dropped from the oldest end only;
         // a smaller stamp never expires anything.
         while (held > 0 && stamp > ring[head] && stamp - ring[head] > window_len) begin
            head = (head + 1) % DEPTH;
            held--;
         end
         if (held >= DEPTH) begin
            head = (head + 1) % DEPTH;
            held = DEPTH - 1;
            overflow = 1'b1;
         end
         ring[(head + held) % DEPTH] = stamp;
         held++;
         if (held > peak) begin
            peak = held;
         end
         want.in_window = COUNT_W'(held);
         want.peak_count = COUNT_W'(peak);
         want.overflowed = overflow;
         want.run_done = last;
         expected_counts.push_back(want);
         if (last) begin
            clear_run();
         end
      endfunction

      task report_mismatch(string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      task check_counts(logic [RSP_DATA_W-1:0] data, logic last);
         result_type want;
         if (expected_counts.size() == 0) begin
            report_mismatch($sformatf("result %h arrived with no stamp waiting", data));
         end else begin
            want = expected_counts.pop_front();
            if (data[COUNT_W-1:0] !== want.in_window) begin
               report_mismatch($sformatf("in_window %0d, expected %0d",
                                         data[COUNT_W-1:0], want.in_window));
            end
            if (data[2*COUNT_W-1:COUNT_W] !== want.peak_count) begin
               report_mismatch($sformatf("peak_count %0d, expected %0d",
                                         data[2*COUNT_W-1:COUNT_W], want.peak_count));
            end
            if (data[2*COUNT_W] !== want.overflowed) begin
               report_mismatch($sformatf("overflowed %b, expected %b",
                                         data[2*COUNT_W], want.overflowed));
            end
            if (data[2*COUNT_W+1] !== 1'b0) begin
               report_mismatch("padding bit of rsp_tdata is not zero");
            end
            if (last !== want.run_done) begin
               report_mismatch($sformatf("rsp_tlast %b, expected %b", last, want.run_done));
            end
         end
      endtask
   endclass

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [31:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_tvalid = 1'b0;
   logic csr_tready;
   logic [31:0] csr_tdata = '0;

   int send_idle_pct = 30;
   int stall_pct = 30;
   int hold_request = 0;
   int hold_left = 0;
   int cycle_count = 0;

   window_count_board board = new();

   peak_events_in_time_window uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Every transaction is observed with the values that stood before the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_tvalid && csr_tready) begin
            board.window_len = csr_tdata;
         end
         if (req_tvalid && req_tready) begin
            board.note_stamp(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            board.check_counts(rsp_tdata, rsp_tlast);
         end
      end
   end

   // The receiver stalls at random, or holds off for a whole stretch on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   task automatic send_item(input logic [31:0] stamp, input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= stamp;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
   endtask

   // The first edge lets the monitor record a transaction accepted at the previous one.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(input logic [31:0] value);
      drain();
      csr_tvalid <= 1'b1;
      csr_tdata <= value;
      @(posedge clock);
      while (!csr_tready) begin
         @(posedge clock);
      end
      csr_tvalid <= 1'b0;
   endtask

   // Runs of mostly non-decreasing stamps whose steps are scaled to the window,
   // with a few out-of-order stamps mixed in.
   task automatic send_runs(input int count, input logic [31:0] win);
      int run_len;
      int pick;
      int unsigned stride;
      logic [31:0] stamp;
      logic [63:0] next_stamp;
      stride = win / 4 + 1;
      while (count > 0) begin
         run_len = $urandom_range(1, 40);
         if (run_len > count) begin
            run_len = count;
         end
         stamp = $urandom;
         for (int i = 0; i < run_len; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
               next_stamp = 64'($urandom);
            end else if (pick < 30) begin
               next_stamp = 64'(stamp);
            end else if (pick < 70) begin
               next_stamp = 64'(stamp) + 64'($urandom_range(0, stride));
            end else if (pick < 90) begin
               next_stamp = 64'(stamp) + 64'(win) + 64'($urandom_range(0, 1));
            end else begin
               next_stamp = 64'(stamp) + 64'($urandom);
            end
            if (next_stamp > 64'(STAMP_MAX)) begin
               next_stamp = 64'(STAMP_MAX);
            end
            stamp = next_stamp[31:0];
            send_item(stamp, i == run_len - 1);
         end
         count -= run_len;
      end
   endtask

   initial begin
      logic [31:0] windows [PHASES];
      int send_pcts [4];
      int stall_pcts [4];
      int half;
      send_pcts = '{0, 75, 0, 30};
      stall_pcts = '{0, 0, 75, 30};
      windows[0] = 1;
      windows[1] = $urandom_range(10, 500);
      windows[2] = 0;
      windows[3] = $urandom;
      windows[4] = $urandom_range(1000, 100000);
      windows[5] = STAMP_MAX;
      windows[6] = 32'h8000_0000 | $urandom;
      windows[7] = $urandom_range(2, 20);
      half = RANDOM_ITEMS / PHASES / 2;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Window at its reset length: a span of exactly the window is kept, one
      // second more expires, and an out-of-order stamp is simply counted.
      send_item(32'd0, 1'b0);
      send_item(32'd0, 1'b0);
      send_item(32'd60, 1'b0);
      send_item(32'd61, 1'b0);
      send_item(32'd30, 1'b0);
      send_item(32'd200, 1'b1);
      send_item(32'hFFFF_FFC0, 1'b0);
      send_item(STAMP_MAX, 1'b0);
      send_item(STAMP_MAX, 1'b1);
      send_item(32'd5, 1'b0);
      send_item(32'd64, 1'b1);
      write_window(32'd0);
      send_item(32'd7, 1'b0);
      send_item(32'd7, 1'b0);
      send_item(32'd8, 1'b1);
      write_window(STAMP_MAX);
      send_item(32'd0, 1'b0);
      send_item(STAMP_MAX, 1'b0);
      send_item(32'd1, 1'b1);
      write_window(32'd1);
      send_item(32'd10, 1'b0);
      send_item(32'd11, 1'b0);
      send_item(32'd12, 1'b1);

      // Fill the store past its depth, then expire everything with one jump.
      write_window(32'd100000);
      send_idle_pct = 0;
      stall_pct = 0;
      for (int i = 0; i < DEPTH + 6; i++) begin
         send_item(32'd5000 + 32'(i / 8), 1'b0);
      end
      send_item(32'd5000000, 1'b0);
      send_item(32'd5000001, 1'b1);

      for (int p = 0; p < PHASES; p++) begin
         write_window(windows[p]);
         send_idle_pct = send_pcts[p % 4];
         stall_pct = stall_pcts[p % 4];
         if (p == 0) begin
            hold_request = HOLD_OFF_CYCLES;
         end
         send_runs(half, windows[p]);
         if (p == 1) begin
            drain();
         end
         send_runs(RANDOM_ITEMS / PHASES - half, windows[p]);
      end

      drain();
      if (board.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/pewin_pkg.sv
hdl/pewin_ring.sv
hdl/pewin_ctrl.sv
hdl/peak_events_in_time_window.sv
hdl/pewin_assert_chk.sv
sim/testbench.sv
